// ===== src/plc_pkg.sv =====
// ----------------------------------------------------------------------------
// plc_pkg: shared types and constants of the print line composer
// Line geometry, field widths, item and result codes, the request passed
// from the front end to the back end, and the alignment decode.
// ----------------------------------------------------------------------------
`default_nettype none

package plc_pkg;

  // line geometry
  localparam int LINE_DOTS   = 384;
  localparam int MAX_ENTRIES = 32;
  localparam int QDEPTH      = 4;   // power of two, pointers wrap naturally

  // fixed field widths
  localparam int TAG_W = 16;
  localparam int DOT_W = 9;
  localparam int ROW_W = 12;
  localparam int OFF_W = 13;
  localparam int CFG_W = 8;

  // used width never exceeds LINE_DOTS - 1 + widest item
  localparam int UW  = $clog2(LINE_DOTS + 512);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int QAW = $clog2(QDEPTH);
  localparam int QCW = $clog2(QDEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] CFG_ALIGNMENT    = 2'd0;
  localparam logic [1:0] CFG_CHAR_SPACING = 2'd1;
  localparam logic [1:0] CFG_LINE_SPACING = 2'd2;

  // alignment selectors
  localparam logic [1:0]       H_CENTER = 2'd1;
  localparam logic [1:0]       H_RIGHT  = 2'd2;
  localparam logic [CFG_W-1:0] V_MIDDLE = 8'd1;
  localparam logic [CFG_W-1:0] V_BOTTOM = 8'd2;

  typedef enum logic [1:0] {MODE_GLYPH, MODE_IMAGE, MODE_FEED, MODE_CLEAR} mode_e;
  typedef enum logic [1:0] {KIND_BLANK, KIND_PLACE, KIND_RETURN} kind_e;
  typedef enum logic [1:0] {OP_PUSH, OP_FLUSH, OP_RET} op_e;
  typedef enum logic [1:0] {SLOT_PRE, SLOT_MAIN, SLOT_SPACE, SLOT_POST} slot_e;
  typedef enum logic {B_IDLE, B_WALK} back_state_e;

  typedef struct packed {
    logic [CFG_W-1:0] alignment;
    logic [CFG_W-1:0] char_spacing;
    logic [CFG_W-1:0] line_spacing;
  } cfg_t;

  typedef struct packed {
    logic             bitmap;
    logic [TAG_W-1:0] tag;
    logic [DOT_W-1:0] width;
    logic [ROW_W-1:0] height;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // request from front to back: store an entry, flush a line, or return only
  typedef struct packed {
    op_e              op;
    logic             last;
    entry_t           ent;
    logic [UW-1:0]    used;
    logic [OFF_W-1:0] lh;
    logic [CW-1:0]    cnt;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    kind_e            kind;
    logic [TAG_W-1:0] tag;
    logic [DOT_W-1:0] width;
    logic [ROW_W-1:0] height;
    logic [OFF_W-1:0] voff;
    logic             last;
  } res_t;

  // a / 3 for 8-bit a, by reciprocal multiply
  function automatic logic [CFG_W-1:0] div3(input logic [CFG_W-1:0] a);
    logic [16:0] p;
    p = 17'(a) * 17'd171;
    return p[16:9];
  endfunction

  // a % 3 for 8-bit a
  function automatic logic [1:0] mod3(input logic [CFG_W-1:0] a);
    logic [9:0]       t;
    logic [CFG_W-1:0] r;
    t = 10'(div3(a)) * 10'd3;
    r = a - t[CFG_W-1:0];
    return r[1:0];
  endfunction

endpackage

`default_nettype wire

// ===== src/plc_ram.sv =====
// ----------------------------------------------------------------------------
// plc_ram: generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== src/plc_front.sv =====
// ----------------------------------------------------------------------------
// plc_front: item intake and line bookkeeping
// Tracks used width, line height and entry count, and turns each item into
// up to four requests (pre-flush, main, spacing, post-flush) for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_front import plc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  output logic             busy_o,
  input  logic [1:0]       mode_i,
  input  logic [TAG_W-1:0] tag_i,
  input  logic [DOT_W-1:0] width_i,
  input  logic [ROW_W-1:0] height_i,
  input  cfg_t             cfg_i,
  input  q_stat_t          q_stat_i,
  output logic             push_o,
  output op_t              op_o
);

  logic             pend_q;
  slot_e            slot_q, slot_d;
  mode_e            mode_q;
  logic [TAG_W-1:0] tag_q;
  logic [DOT_W-1:0] w_q;
  logic [ROW_W-1:0] h_q;
  logic [UW-1:0]    used_q, used_d;
  logic [OFF_W-1:0] lh_q, lh_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  logic             is_item, glyph, pre, post1, post2, post, sp;
  logic             slot_vld, advance;
  logic [OFF_W-1:0] lh_item, lh0, lh1;
  logic [UW-1:0]    fit_sum, u0, u1, uc;
  logic [CW-1:0]    c0, c1;
  op_t              slot_op;

  assign is_item = (mode_q == MODE_GLYPH) || (mode_q == MODE_IMAGE);
  assign glyph   = (mode_q == MODE_GLYPH);

  assign lh_item = glyph ? OFF_W'(h_q) + OFF_W'(cfg_i.line_spacing) : OFF_W'(h_q);
  assign fit_sum = used_q + UW'(w_q);
  assign pre     = is_item && ((fit_sum > UW'(LINE_DOTS)) || (cnt_q >= CW'(MAX_ENTRIES)));

  assign u0  = pre ? '0 : used_q;
  assign lh0 = pre ? '0 : lh_q;
  assign c0  = pre ? '0 : cnt_q;
  assign u1  = u0 + UW'(w_q);
  assign lh1 = (lh0 < lh_item) ? lh_item : lh0;
  assign c1  = c0 + CW'(1);
  assign uc  = u1 + UW'(cfg_i.char_spacing);

  assign post1 = is_item && (u1 >= UW'(LINE_DOTS));
  assign post2 = glyph && !post1 && ((uc >= UW'(LINE_DOTS)) || (c1 >= CW'(MAX_ENTRIES)));
  assign post  = post1 || post2;
  assign sp    = glyph && !post1 && !post2;

  always_comb begin
    slot_vld = 1'b0;
    slot_op  = '0;
    unique case (slot_q)
      SLOT_PRE: begin
        slot_vld      = pre;
        slot_op.op    = OP_FLUSH;
        slot_op.last  = !post;  // ends the output unless a post-flush follows
        slot_op.used  = used_q;
        slot_op.lh    = lh_q;
        slot_op.cnt   = cnt_q;
      end
      SLOT_MAIN: begin
        slot_vld = 1'b1;
        unique case (mode_q)
          MODE_GLYPH, MODE_IMAGE: begin
            slot_op.op         = OP_PUSH;
            slot_op.ent.bitmap = 1'b1;
            slot_op.ent.tag    = tag_q;
            slot_op.ent.width  = w_q;
            slot_op.ent.height = h_q;
          end
          MODE_FEED: begin
            slot_op.op   = OP_FLUSH;
            slot_op.last = 1'b1;
            slot_op.used = used_q;
            slot_op.lh   = lh_q;
            slot_op.cnt  = cnt_q;
          end
          MODE_CLEAR: begin
            slot_op.op   = OP_RET;
            slot_op.last = 1'b1;
          end
        endcase
      end
      SLOT_SPACE: begin
        slot_vld          = sp;
        slot_op.op        = OP_PUSH;
        slot_op.ent.width = DOT_W'(cfg_i.char_spacing);
      end
      SLOT_POST: begin
        slot_vld     = post;
        slot_op.op   = OP_FLUSH;
        slot_op.last = 1'b1;
        slot_op.used = u1;
        slot_op.lh   = lh1;
        slot_op.cnt  = c1;
      end
    endcase
  end

  assign op_o = slot_op;

  assign advance = pend_q && (!slot_vld || !q_stat_i.full);
  assign push_o  = pend_q && slot_vld && !q_stat_i.full;
  assign busy_o  = pend_q;

  always_comb begin
    slot_d = slot_q;
    unique case (slot_q)
      SLOT_PRE:   slot_d = SLOT_MAIN;
      SLOT_MAIN:  slot_d = SLOT_SPACE;
      SLOT_SPACE: slot_d = SLOT_POST;
      SLOT_POST:  slot_d = SLOT_PRE;
    endcase
  end

  always_comb begin
    if (!is_item || post) begin
      used_d = '0;
      lh_d   = '0;
      cnt_d  = '0;
    end else begin
      used_d = sp ? uc : u1;
      lh_d   = lh1;
      cnt_d  = sp ? c1 + CW'(1) : c1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      slot_q <= SLOT_PRE;
      used_q <= '0;
      lh_q   <= '0;
      cnt_q  <= '0;
    end else if (start_i && !pend_q) begin
      pend_q <= 1'b1;
      slot_q <= SLOT_PRE;
    end else if (advance) begin
      slot_q <= slot_d;
      if (slot_q == SLOT_POST) begin
        pend_q <= 1'b0;
        used_q <= used_d;
        lh_q   <= lh_d;
        cnt_q  <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !pend_q) begin
      mode_q <= mode_e'(mode_i);
      tag_q  <= tag_i;
      w_q    <= width_i;
      h_q    <= height_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/plc_queue.sv =====
// ----------------------------------------------------------------------------
// plc_queue: request queue between front and back end
// Small FIFO of requests; full and empty travel back as one status word.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_queue import plc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  op_t     op_i,
  input  logic    pop_i,
  output op_t     head_o,
  output q_stat_t stat_o
);

  op_t            mem_q [QDEPTH];
  logic [QAW-1:0] wr_q, rd_q;
  logic [QCW-1:0] cnt_q;

  assign head_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == QCW'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + QAW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + QAW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= op_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/plc_back.sv =====
// ----------------------------------------------------------------------------
// plc_back: entry store and line flush sequencer
// Stores entries; on a flush emits the margin, walks the store one entry
// per cycle and ends with a carriage return; OP_RET emits only the return.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_back import plc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [CFG_W-1:0] alignment_i,
  input  q_stat_t          q_stat_i,
  input  op_t              head_i,
  output logic             pop_o,
  output logic             strobe_o,
  output res_t             res_o
);

  back_state_e      st_q, st_d;
  logic [CW-1:0]    idx_q, idx_d, cnt_s_q, cnt_s_d, wptr_q, wptr_d, nidx;
  logic [OFF_W-1:0] lh_s_q, lh_s_d;
  logic             last_s_q, last_s_d;
  logic             strobe_q, strobe_d;
  res_t             res_q, res_d;

  logic               we;
  logic [AW-1:0]      raddr;
  logic [ENTRY_W-1:0] rdata;
  entry_t             ent;

  logic [1:0]       hsel;
  logic [CFG_W-1:0] vsel;
  logic [UW-1:0]    room, margin;
  logic [OFF_W-1:0] gap, off;

  plc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wptr_q[AW-1:0]),
    .wdata_i (head_i.ent),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign hsel = mod3(alignment_i);
  assign vsel = div3(alignment_i);
  assign ent  = entry_t'(rdata);
  assign nidx = idx_q + CW'(1);

  assign room   = (head_i.used < UW'(LINE_DOTS)) ? UW'(LINE_DOTS) - head_i.used : '0;
  assign margin = (hsel == H_CENTER) ? (room >> 1) : (hsel == H_RIGHT) ? room : '0;

  assign gap = (lh_s_q > OFF_W'(ent.height)) ? lh_s_q - OFF_W'(ent.height) : '0;
  assign off = (vsel == V_MIDDLE) ? (gap >> 1) : (vsel == V_BOTTOM) ? gap : '0;

  always_comb begin
    st_d     = st_q;
    idx_d    = idx_q;
    cnt_s_d  = cnt_s_q;
    lh_s_d   = lh_s_q;
    last_s_d = last_s_q;
    wptr_d   = wptr_q;
    strobe_d = 1'b0;
    res_d    = res_q;
    pop_o    = 1'b0;
    we       = 1'b0;
    raddr    = '0;
    unique case (st_q)
      B_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o = 1'b1;
          unique case (head_i.op)
            OP_PUSH: begin
              we     = 1'b1;
              wptr_d = wptr_q + CW'(1);
            end
            OP_FLUSH: begin
              strobe_d   = 1'b1;
              res_d      = '0;
              res_d.kind = KIND_BLANK;
              res_d.width = DOT_W'(margin);
              idx_d      = '0;
              cnt_s_d    = head_i.cnt;
              lh_s_d     = head_i.lh;
              last_s_d   = head_i.last;
              st_d       = B_WALK;
            end
            OP_RET: begin
              strobe_d   = 1'b1;
              res_d      = '0;
              res_d.kind = KIND_RETURN;
              res_d.last = head_i.last;
              wptr_d     = '0;
            end
            default: begin
            end
          endcase
        end
      end
      B_WALK: begin
        strobe_d = 1'b1;
        res_d    = '0;
        if (idx_q < cnt_s_q) begin
          raddr = nidx[AW-1:0];
          idx_d = nidx;
          res_d.width = ent.width;
          if (ent.bitmap) begin
            res_d.kind   = KIND_PLACE;
            res_d.tag    = ent.tag;
            res_d.height = ent.height;
            res_d.voff   = off;
          end else begin
            res_d.kind = KIND_BLANK;
          end
        end else begin
          res_d.kind = KIND_RETURN;
          res_d.last = last_s_q;
          wptr_d     = '0;
          st_d       = B_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= B_IDLE;
      idx_q    <= '0;
      cnt_s_q  <= '0;
      wptr_q   <= '0;
      strobe_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      idx_q    <= idx_d;
      cnt_s_q  <= cnt_s_d;
      wptr_q   <= wptr_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lh_s_q   <= lh_s_d;
    last_s_q <= last_s_d;
    res_q    <= res_d;
  end

  assign strobe_o = strobe_q;
  assign res_o    = res_q;

endmodule

`default_nettype wire

// ===== src/print_line_composer_top.sv =====
// ----------------------------------------------------------------------------
// print_line_composer_top: print line composer
// Gathers glyph and image items for one print line and, on a flush, emits
// the left margin, every placement with its vertical offset, and a return.
// ----------------------------------------------------------------------------
// Using the block: an item is taken when start is high and busy is low, and
// occupies the front end while it is captured and then stepped through
// four request slots, after which busy drops and the next item may follow;
// busy also stays up while the four-deep request queue is full. Results
// appear on the result ports one per cycle, each for a single cycle marked
// by result_strobe_o, and cannot be held off, so the receiver must take
// every strobe. A flush of n stored entries takes the back end through the
// margin, the n entries and the return, paced by the single read port of the
// entry store; an item can cause two flushes, up to 37 results in all, and
// last_o marks the return that ends its output. The entry store needs no
// clearing pass: a fill count bounds every walk. Configuration writes are
// always accepted (cfg_ready_o stays high) and belong to idle periods: all
// results delivered and, after an item that emits nothing, its requests drained.
// ----------------------------------------------------------------------------
`default_nettype none

module print_line_composer_top import plc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // item requests
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       mode_i,
  input  logic [TAG_W-1:0] item_tag_i,
  input  logic [DOT_W-1:0] item_width_i,
  input  logic [ROW_W-1:0] item_height_i,
  // configuration writes
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  // results
  output logic             result_strobe_o,
  output logic [1:0]       kind_o,
  output logic [TAG_W-1:0] out_tag_o,
  output logic [DOT_W-1:0] out_width_o,
  output logic [ROW_W-1:0] out_height_o,
  output logic [OFF_W-1:0] vertical_offset_o,
  output logic             last_o
);

  cfg_t    cfg_q;
  logic    push, pop;
  op_t     push_op, head_op;
  q_stat_t q_stat;
  res_t    res;

  // configuration registers; indexes beyond the list are dropped
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ALIGNMENT:    cfg_q.alignment    <= cfg_data_i;
        CFG_CHAR_SPACING: cfg_q.char_spacing <= cfg_data_i;
        CFG_LINE_SPACING: cfg_q.line_spacing <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // front end: decides fits and flushes, issues requests
  plc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .busy_o   (busy),
    .mode_i   (mode_i),
    .tag_i    (item_tag_i),
    .width_i  (item_width_i),
    .height_i (item_height_i),
    .cfg_i    (cfg_q),
    .q_stat_i (q_stat),
    .push_o   (push),
    .op_o     (push_op)
  );

  // request queue decouples intake from the flush walk
  plc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (push_op),
    .pop_i  (pop),
    .head_o (head_op),
    .stat_o (q_stat)
  );

  // back end: owns the entry store and emits results
  plc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .alignment_i (cfg_q.alignment),
    .q_stat_i    (q_stat),
    .head_i      (head_op),
    .pop_o       (pop),
    .strobe_o    (result_strobe_o),
    .res_o       (res)
  );

  assign kind_o            = res.kind;
  assign out_tag_o         = res.tag;
  assign out_width_o       = res.width;
  assign out_height_o      = res.height;
  assign vertical_offset_o = res.voff;
  assign last_o            = res.last;

endmodule

`default_nettype wire

// ===== src/plc_checker.sv =====
// ----------------------------------------------------------------------------
// plc_checker: port-level checks of the print line composer
// Watches the result and request ports over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module plc_checker import plc_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             result_strobe_o,
  input logic [1:0]       kind_o,
  input logic [TAG_W-1:0] out_tag_o,
  input logic [DOT_W-1:0] out_width_o,
  input logic [ROW_W-1:0] out_height_o,
  input logic [OFF_W-1:0] vertical_offset_o,
  input logic             last_o
);

  // the final result of a request is always the carriage return
  a_last_is_return: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && last_o |-> kind_o == KIND_RETURN)
    else $error("last result is not a carriage return");

  // a placement is inside a flush walk, so another result follows at once
  a_place_followed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && kind_o == KIND_PLACE |=> result_strobe_o)
    else $error("gap in flush after a placement");

  // only placements carry tag, height and offset
  a_blank_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && kind_o != KIND_PLACE |->
      out_tag_o == '0 && out_height_o == '0 && vertical_offset_o == '0)
    else $error("non-placement result with placement fields");

  // an accepted request holds the intake for the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("intake free right after accepting a request");

  // a return skips no columns
  a_return_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && kind_o == KIND_RETURN |-> out_width_o == '0)
    else $error("carriage return with nonzero width");

endmodule

bind print_line_composer_top plc_checker u_plc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .result_strobe_o   (result_strobe_o),
  .kind_o            (kind_o),
  .out_tag_o         (out_tag_o),
  .out_width_o       (out_width_o),
  .out_height_o      (out_height_o),
  .vertical_offset_o (vertical_offset_o),
  .last_o            (last_o)
);

`default_nettype wire
